// ----- rtl/hbp_pkg.sv -----
// Shared constants for the table-driven bit packer: command codes,
// input field widths and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package hbp_pkg;

  // Command codes carried on the slave-side tuser.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Field widths of one input word and one output word.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned LEN_IN_W  = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned S_TDATA_W = 48;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_CODE_LEN = 32;
  localparam int unsigned DEF_NUM_SYMBOLS  = 256;

endpackage

// ----- rtl/huffman_bit_packer.sv -----
// Top level of the table-driven bit packer: code table, bit accumulator and
// the shared merge/shift unit with its sequencer. Depends on hbp_pkg.
`timescale 1ns / 1ps

// A load word is taken in the idle state and written to the table. An encode word
// reads the table on acceptance, loads the code register in the read state, then
// closes one output byte per step of the run state and takes a last step when bits
// are left over for the accumulator or the code is empty. A flush word with pending
// bits runs the unit until the byte closes; one without only clears the accumulator.
// Throughput is set by the single merge/shift unit, which moves at most one
// byte's worth of code bits per cycle; the output register can stall it.
// Reset clears the accumulator, the sequencer and every valid bit of the code
// table, so all entries read as length zero right after reset.
module huffman_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
  parameter int unsigned NUM_SYMBOLS  = hbp_pkg::DEF_NUM_SYMBOLS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata fields from bit 0: symbol[7:0], code_value[39:8], code_length[45:40], zero pad.
  input  logic [hbp_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser fields from bit 0: cmd[1:0].
  input  logic [hbp_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata fields from bit 0: out_byte[7:0].
  output logic [hbp_pkg::BYTE_W-1:0]     m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import hbp_pkg::*;

  // Stored code width: a loaded length never exceeds this, so wider bits are dead.
  localparam int unsigned CODE_W = (MAX_CODE_LEN < VAL_W) ? MAX_CODE_LEN : VAL_W;
  localparam int unsigned LEN_W  = $clog2(CODE_W + 1);
  localparam int unsigned IDX_W  = $clog2(NUM_SYMBOLS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // Input word fields.
  logic [SYM_W-1:0]    sym;
  logic [VAL_W-1:0]    value;
  logic [LEN_IN_W-1:0] len_in;
  assign sym    = s_axis_tdata_i[SYM_W-1:0];
  assign value  = s_axis_tdata_i[SYM_W+VAL_W-1:SYM_W];
  assign len_in = s_axis_tdata_i[SYM_W+VAL_W+LEN_IN_W-1:SYM_W+VAL_W];

  logic [1:0]  state_q;
  logic [6:0]  acc_q;          // pending bits, right aligned
  logic [2:0]  cnt_q;          // number of valid pending bits
  logic [CODE_W-1:0] code_q;   // remaining code bits, next bit at the MSB
  logic [LEN_W-1:0]  rem_q;    // number of remaining code bits
  logic        m_valid_q;
  logic [BYTE_W-1:0] m_data_q;
  logic        m_last_q;

  // Code table. Codes are stored left aligned so the unit always takes the top bits.
  logic [CODE_W-1:0] mem_code [NUM_SYMBOLS];
  logic [LEN_W-1:0]  mem_len  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid_q;
  logic [CODE_W-1:0] rd_code_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic              hit_q;

  logic accept, in_range;
  logic [IDX_W-1:0] idx;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = {1'b0, sym} < (SYM_W + 1)'(NUM_SYMBOLS);
  assign idx      = sym[IDX_W-1:0];

  // Length saturation and left alignment for a table write.
  logic [LEN_IN_W-1:0] len_sat;
  logic [5:0]          align_sh;
  logic [VAL_W-1:0]    aligned;
  assign len_sat  = (len_in > LEN_IN_W'(CODE_W)) ? LEN_IN_W'(CODE_W) : len_in;
  assign align_sh = 6'(VAL_W) - 6'(len_sat);
  assign aligned  = value << align_sh;

  // Shared merge unit: takes up to the bits still missing from the current
  // byte off the top of the code register and shifts them into the accumulator.
  logic [3:0]  need, take;
  logic [7:0]  top8;
  logic [15:0] merged;
  logic [LEN_W-1:0] rem_after;
  logic        step, fills, emit_byte;
  assign need      = 4'd8 - {1'b0, cnt_q};
  assign take      = (rem_q < LEN_W'(need)) ? rem_q[3:0] : need;
  assign top8      = code_q[CODE_W-1 -: 8];
  assign merged    = ({9'b0, acc_q} << take) | {8'b0, top8 >> (4'd8 - take)};
  assign rem_after = rem_q - LEN_W'(take);
  assign fills     = (take == need);
  // The unit only advances when the output register is free or being emptied.
  assign step      = (state_q == ST_RUN) && (!m_valid_q || m_axis_tready_i);
  // A full byte leaves the unit in this cycle.
  assign emit_byte = step && (rem_q != '0) && fills;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // Table storage: write on load, registered read on encode.
  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser_i == CMD_LOAD && in_range) begin
      mem_code[idx] <= aligned[VAL_W-1 -: CODE_W];
      mem_len[idx]  <= LEN_W'(len_sat);
    end
    if (accept && s_axis_tuser_i == CMD_ENCODE) begin
      rd_code_q <= mem_code[idx];
      rd_len_q  <= mem_len[idx];
    end
  end

  // Valid bits make an unloaded entry read as length zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else if (accept) begin
      if (s_axis_tuser_i == CMD_LOAD && in_range) begin
        valid_q[idx] <= 1'b1;
      end
      if (s_axis_tuser_i == CMD_ENCODE) begin
        hit_q <= in_range && valid_q[idx];
      end
    end
  end

  // Output payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (step && rem_q != '0 && fills) begin
      m_data_q <= merged[7:0];
      m_last_q <= (rem_after < LEN_W'(8));
    end
  end

  // Sequencer, accumulator and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      code_q    <= '0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // A new byte refills the output register; otherwise a taken byte empties it.
      if (emit_byte) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_axis_tuser_i)
              CMD_ENCODE: state_q <= ST_READ;
              CMD_FLUSH: begin
                // A flush pushes zero bits until the byte closes.
                if (cnt_q != 3'd0) begin
                  code_q  <= '0;
                  rem_q   <= LEN_W'(need);
                  state_q <= ST_RUN;
                end else begin
                  acc_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          code_q  <= hit_q ? rd_code_q : '0;
          rem_q   <= hit_q ? rd_len_q  : '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (step) begin
            if (rem_q == '0) begin
              state_q <= ST_IDLE;
            end else if (fills) begin
              acc_q     <= '0;
              cnt_q     <= '0;
              code_q    <= code_q << take;
              rem_q     <= rem_after;
              if (rem_after == '0) begin
                state_q <= ST_IDLE;
              end
            end else begin
              // Too few bits left for a byte: park them in the accumulator.
              acc_q   <= merged[6:0];
              cnt_q   <= cnt_q + take[2:0];
              rem_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A load never disturbs the pending bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i == CMD_LOAD) |=> ($stable(cnt_q) && $stable(acc_q)))
    else $error("load changed pending bits");

  // An encode word always goes through the table read cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i == CMD_ENCODE) |=> (state_q == ST_READ))
    else $error("encode skipped table read");

  // Closing a byte empties the accumulator and raises the output valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && rem_q != '0 && fills) |=> (cnt_q == 3'd0 && m_valid_q))
    else $error("byte emission left bits pending");

  // A code fetched from the table never exceeds the stored width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (rem_q <= LEN_W'(CODE_W)))
    else $error("code length above table width");

endmodule

// ----- tb/sv/tb_huffman_bit_packer.sv -----
// Self-checking testbench for huffman_bit_packer: drives load, encode and flush
// words with random idling on both streams and checks every packed byte and its
// tlast against an in-bench prediction. Depends on hbp_pkg and the packer RTL.
`timescale 1ns / 1ps

module tb_huffman_bit_packer;
  import hbp_pkg::*;

  localparam int unsigned CODE_LEN_CAP = (DEF_MAX_CODE_LEN < VAL_W) ? DEF_MAX_CODE_LEN : VAL_W;
  localparam int unsigned NUM_RANDOM   = 310;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SYM_W-1:0]    sym;
    logic [VAL_W-1:0]    code_val;
    logic [LEN_IN_W-1:0] code_len;
    logic                drain;     // hold this word back until all bytes are out
  } pack_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } packed_byte_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [CMD_W-1:0]     s_axis_tuser_i = CMD_NONE;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  huffman_bit_packer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted packer state: code table plus the bits still waiting for a byte.
  logic [VAL_W-1:0]    code_val_tbl [DEF_NUM_SYMBOLS];
  logic [LEN_IN_W-1:0] code_len_tbl [DEF_NUM_SYMBOLS];
  logic [6:0]          acc_bits;
  int unsigned         acc_cnt;

  pack_word_t   stim_q [$];
  packed_byte_t exp_bytes [$];
  pack_word_t   drv_word;

  int unsigned issued_cnt = 0, accepted_cnt = 0, bytes_got = 0, out_seen = 0;
  int unsigned in_wait = 0, out_wait = 0, in_calm = 0, out_calm = 0;
  int unsigned errors = 0, cycle_cnt = 0;
  int unsigned n_load = 0, n_encode = 0, n_flush = 0, n_noop = 0;
  bit          drv_active = 1'b0;

  // Wait before the next word on one side: a random idle time, with occasional calm
  // stretches in which no idling happens at all.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
    return $urandom_range(0, 8);
  endfunction

  function automatic pack_word_t mk_word(logic [CMD_W-1:0] cmd, int unsigned sym,
                                         logic [VAL_W-1:0] val, int unsigned len,
                                         bit drain = 1'b0);
    pack_word_t w;
    w.cmd      = cmd;
    w.sym      = SYM_W'(sym);
    w.code_val = val;
    w.code_len = LEN_IN_W'(len);
    w.drain    = drain;
    return w;
  endfunction

  task automatic predict_word(input pack_word_t w);
    logic [7:0]          acc;
    logic [VAL_W-1:0]    code;
    int unsigned         clen, n;
    logic [BYTE_W-1:0]   outs [4];
    case (w.cmd)
      CMD_LOAD: begin
        n_load++;
        if (w.sym < DEF_NUM_SYMBOLS) begin
          code_val_tbl[w.sym] = w.code_val;
          code_len_tbl[w.sym] = (w.code_len > CODE_LEN_CAP) ? LEN_IN_W'(CODE_LEN_CAP)
                                                             : w.code_len;
        end
      end
      CMD_ENCODE: begin
        n_encode++;
        acc  = {1'b0, acc_bits};
        code = '0;
        clen = 0;
        n    = 0;
        if (w.sym < DEF_NUM_SYMBOLS) begin
          code = code_val_tbl[w.sym];
          clen = code_len_tbl[w.sym];
        end
        // Shift the code in from its top valid bit down, cutting a byte every 8.
        for (int i = clen; i > 0; i--) begin
          acc = {acc[6:0], code[i-1]};
          acc_cnt++;
          if (acc_cnt == 8) begin
            outs[n] = acc;
            n++;
            acc     = '0;
            acc_cnt = 0;
          end
        end
        acc_bits = acc[6:0];
        for (int k = 0; k < n; k++) exp_bytes.push_back('{outs[k], k == n - 1});
      end
      CMD_FLUSH: begin
        n_flush++;
        if (acc_cnt != 0) exp_bytes.push_back('{8'({1'b0, acc_bits}) << (8 - acc_cnt), 1'b1});
        acc_bits = '0;
        acc_cnt  = 0;
      end
      default: n_noop++;
    endcase
  endtask

  // Input side: one word at a time from stim_q, changed on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drv_active && accepted_cnt == issued_cnt) begin
        drv_active = 1'b0;
        in_wait    = draw_wait(in_calm);
      end
      if (!drv_active) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (stim_q.size() != 0 && !(stim_q[0].drain && exp_bytes.size() != 0)) begin
          drv_word = stim_q.pop_front();
          s_axis_tdata_i <= {2'b00, drv_word.code_len, drv_word.code_val, drv_word.sym};
          s_axis_tuser_i <= drv_word.cmd;
          drv_active = 1'b1;
          issued_cnt++;
        end
      end
      s_axis_tvalid_i <= drv_active;
    end
  end

  // Output side: after each byte taken, hold tready low for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_seen != bytes_got) begin
        out_seen = bytes_got;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait > 0) begin
        out_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Sample both handshakes at the rising edge. The output is checked before the
  // input word of the same edge is predicted, since it cannot stem from it.
  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        bytes_got++;
        if (exp_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected byte %02h last %0b", m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          want = exp_bytes.pop_front();
          if (m_axis_tdata_o !== want.out_byte || m_axis_tlast_o !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: byte %0d expected %02h last %0b, got %02h last %0b",
                       bytes_got, want.out_byte, want.last, m_axis_tdata_o, m_axis_tlast_o);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_word(drv_word);
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_cnt, exp_bytes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned live_syms [$];
    int unsigned useful, sym, len, pick;
    pack_word_t  w;

    for (int i = 0; i < DEF_NUM_SYMBOLS; i++) begin
      code_val_tbl[i] = '0;
      code_len_tbl[i] = '0;
    end
    acc_bits = '0;
    acc_cnt  = 0;

    // Directed part: empty table, empty flush, the unused command, length
    // saturation, zero-length entries, full-width codes across a partial byte,
    // reloading an entry and the extremes of each field.
    stim_q.push_back(mk_word(CMD_ENCODE, 0, '0, 0));
    stim_q.push_back(mk_word(CMD_FLUSH, 255, '1, 63));
    stim_q.push_back(mk_word(CMD_NONE, 255, '1, 63));
    stim_q.push_back(mk_word(CMD_LOAD, 0, 32'hFFFF_FFFF, 0));
    stim_q.push_back(mk_word(CMD_ENCODE, 0, '0, 0));
    stim_q.push_back(mk_word(CMD_LOAD, 255, 32'hA5C3_0F96, 32));
    stim_q.push_back(mk_word(CMD_ENCODE, 255, '0, 0));
    stim_q.push_back(mk_word(CMD_LOAD, 1, 32'hFFFF_FFFF, 63));
    stim_q.push_back(mk_word(CMD_LOAD, 2, 32'h1234_5678, 33));
    stim_q.push_back(mk_word(CMD_LOAD, 3, 32'h0000_0055, 7));
    stim_q.push_back(mk_word(CMD_ENCODE, 3, '0, 0));
    stim_q.push_back(mk_word(CMD_ENCODE, 1, '0, 0));
    stim_q.push_back(mk_word(CMD_FLUSH, 0, '0, 0));
    stim_q.push_back(mk_word(CMD_ENCODE, 2, '0, 0));
    stim_q.push_back(mk_word(CMD_FLUSH, 0, '0, 0));
    stim_q.push_back(mk_word(CMD_LOAD, 4, 32'hFFFF_FFFF, 1));
    stim_q.push_back(mk_word(CMD_ENCODE, 4, '0, 0));
    stim_q.push_back(mk_word(CMD_FLUSH, 0, '0, 0));
    stim_q.push_back(mk_word(CMD_LOAD, 5, 32'h0000_003C, 8));
    stim_q.push_back(mk_word(CMD_ENCODE, 5, '0, 0));
    stim_q.push_back(mk_word(CMD_LOAD, 255, 32'h0000_0000, 31));
    stim_q.push_back(mk_word(CMD_ENCODE, 4, '0, 0));
    stim_q.push_back(mk_word(CMD_ENCODE, 255, '0, 0, 1'b1));
    stim_q.push_back(mk_word(CMD_FLUSH, 0, '0, 0));

    // Random part: build a code set first, then mostly encode from it, with
    // flushes, reloads, stray symbols and the unused command mixed in.
    for (int i = 0; i < 12; i++) begin
      sym = $urandom_range(0, DEF_NUM_SYMBOLS - 1);
      live_syms.push_back(sym);
      stim_q.push_back(mk_word(CMD_LOAD, sym, $urandom, $urandom_range(1, 12)));
    end
    useful = 12;
    while (useful < NUM_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      len = $urandom_range(1, 12);
        else if (pick < 90) len = $urandom_range(13, 32);
        else if (pick < 95) len = 0;
        else                len = $urandom_range(33, 63);
        if ($urandom_range(0, 2) == 0) sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
        else                           sym = $urandom_range(0, DEF_NUM_SYMBOLS - 1);
        live_syms.push_back(sym);
        w = mk_word(CMD_LOAD, sym, $urandom, len);
      end else if (pick < 85) begin
        if ($urandom_range(0, 99) < 85) sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
        else                            sym = $urandom_range(0, DEF_NUM_SYMBOLS - 1);
        w = mk_word(CMD_ENCODE, sym, $urandom, $urandom_range(0, 63));
      end else if (pick < 95) begin
        w = mk_word(CMD_FLUSH, $urandom, $urandom, $urandom_range(0, 63));
      end else begin
        w = mk_word(CMD_NONE, $urandom, $urandom, $urandom_range(0, 63));
      end
      // Now and then let the output side run completely dry before going on.
      w.drain = ($urandom_range(0, 59) == 0);
      stim_q.push_back(w);
      if (w.cmd != CMD_NONE) useful++;
    end
    stim_q.push_back(mk_word(CMD_FLUSH, 0, '0, 0, 1'b1));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (stim_q.size() == 0 && !drv_active);
    while (exp_bytes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (exp_bytes.size() != 0) begin
      errors++;
      $display("ERROR: %0d expected bytes never arrived", exp_bytes.size());
    end
    $display("Covered %0d loads, %0d encodes, %0d flushes and %0d unused commands;",
             n_load, n_encode, n_flush, n_noop);
    $display("%0d packed bytes checked, %0d mismatching.", bytes_got, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
